[design/csa_pkg.sv]
// Shared constants and types for the count-smaller-after-self block.
`default_nettype none
package csa_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int VALUE_W       = 32;
  localparam int COUNT_W       = 6;
  localparam int POS_W         = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

[design/csa_in_if.sv]
// Request channel carrying one set element per transfer.
`default_nettype none
interface csa_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [csa_pkg::VALUE_W-1:0]  value;
  logic                                is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface
`default_nettype wire

[design/csa_out_if.sv]
// Result channel carrying one per-element count per transfer.
`default_nettype none
interface csa_out_if;
  logic                         valid;
  logic                         ready;
  logic [csa_pkg::COUNT_W-1:0]  smaller_count;
  logic [csa_pkg::POS_W-1:0]    position;
  logic                         last_result;
  logic                         overflow;

  modport source (output valid, output smaller_count, output position,
                  output last_result, output overflow, input ready);
  modport sink   (input valid, input smaller_count, input position,
                  input last_result, input overflow, output ready);
endinterface
`default_nettype wire

[design/count_smaller_after_self.sv]
// Top level: per-element count of later strictly smaller values, memory based.
// Each accepted request scans the elements stored before it, one memory read per stored element
//   through the value/count read-modify-write loop; a new request is taken only after that scan.
// Results leave after the closing request's scan, one memory read per result; a read is issued
//   only when the result register is empty or being taken, so a stalled output holds the reads.
// Reset: fill level and drop flag clear synchronously; both memories keep their contents.
`default_nettype none
module count_smaller_after_self #(
  parameter int MAX_ITEMS = csa_pkg::MAX_ITEMS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  csa_in_if.sink     in_if,
  csa_out_if.source  out_if
);
  import csa_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  // storage
  logic signed [VALUE_W-1:0] val_mem [MAX_ITEMS];
  logic [COUNT_W-1:0]        cnt_mem [MAX_ITEMS];
  logic signed [VALUE_W-1:0] val_q;
  logic [COUNT_W-1:0]        cnt_q;

  // control
  state_t                    state_r, state_nxt;
  logic [CW-1:0]             fill_r, fill_nxt;
  logic                      drop_r, drop_nxt;
  logic [CW-1:0]             scan_n_r, scan_n_nxt;
  logic [CW-1:0]             rd_idx_r, rd_idx_nxt;
  logic                      rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]             wb_addr_r, wb_addr_nxt;
  logic                      last_r, last_nxt;
  logic signed [VALUE_W-1:0] v_r, v_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // output payload
  logic [COUNT_W-1:0]        out_cnt_r, out_cnt_nxt;
  logic [POS_W-1:0]          out_pos_r, out_pos_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_ovf_r, out_ovf_nxt;

  logic                      in_fire;
  logic                      out_fire;
  logic                      is_full;
  logic                      rd_go;
  logic                      val_we;
  logic                      cnt_we;
  logic [AW-1:0]             cnt_waddr;
  logic [COUNT_W-1:0]        cnt_wdata;

  assign in_fire  = in_if.valid && (state_r == ST_IDLE);
  assign out_fire = out_valid_r && out_if.ready;
  assign is_full  = (fill_r == CW'(MAX_ITEMS));

  assign out_if.valid         = out_valid_r;
  assign out_if.smaller_count = out_cnt_r;
  assign out_if.position      = out_pos_r;
  assign out_if.last_result   = out_last_r;
  assign out_if.overflow      = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    scan_n_nxt    = scan_n_r;
    rd_idx_nxt    = rd_idx_r;
    rd_pend_nxt   = 1'b0;
    wb_addr_nxt   = wb_addr_r;
    last_nxt      = last_r;
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r && !out_fire;
    out_cnt_nxt   = out_cnt_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    in_if.ready   = 1'b0;
    rd_go         = 1'b0;
    val_we        = 1'b0;
    cnt_we        = 1'b0;
    cnt_waddr     = fill_r[AW-1:0];
    cnt_wdata     = '0;

    unique case (state_r)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_fire) begin
          v_nxt      = in_if.value;
          last_nxt   = in_if.is_last;
          rd_idx_nxt = '0;
          state_nxt  = ST_SCAN;
          if (is_full) begin
            drop_nxt   = 1'b1;
            scan_n_nxt = '0;
          end else begin
            val_we     = 1'b1;
            cnt_we     = 1'b1;
            scan_n_nxt = fill_r;
            fill_nxt   = fill_r + CW'(1);
          end
        end
      end
      ST_SCAN: begin
        // write back the count read last cycle
        if (rd_pend_r && (val_q > v_r) && (cnt_q != COUNT_MAX)) begin
          cnt_we    = 1'b1;
          cnt_waddr = wb_addr_r;
          cnt_wdata = cnt_q + COUNT_W'(1);
        end
        if (rd_idx_r < scan_n_r) begin
          rd_go       = 1'b1;
          rd_pend_nxt = 1'b1;
          wb_addr_nxt = rd_idx_r[AW-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end else if (!rd_pend_r) begin
          rd_idx_nxt = '0;
          state_nxt  = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (rd_pend_r) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cnt_q;
          out_pos_nxt   = POS_W'(wb_addr_r);
          out_last_nxt  = (CW'(wb_addr_r) == fill_r - CW'(1));
          out_ovf_nxt   = drop_r;
        end else if (rd_idx_r < fill_r) begin
          if (!out_valid_r || out_if.ready) begin
            rd_go       = 1'b1;
            rd_pend_nxt = 1'b1;
            wb_addr_nxt = rd_idx_r[AW-1:0];
            rd_idx_nxt  = rd_idx_r + CW'(1);
          end
        end else begin
          fill_nxt  = '0;
          drop_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      drop_r      <= 1'b0;
      scan_n_r    <= '0;
      rd_idx_r    <= '0;
      rd_pend_r   <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      drop_r      <= drop_nxt;
      scan_n_r    <= scan_n_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r  <= wb_addr_nxt;
    v_r        <= v_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // value memory
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[fill_r[AW-1:0]] <= in_if.value;
    end
    if (rd_go) begin
      val_q <= val_mem[rd_idx_r[AW-1:0]];
    end
  end

  // count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (rd_go) begin
      cnt_q <= cnt_mem[rd_idx_r[AW-1:0]];
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_ITEMS))
    else $error("fill level beyond capacity");

  a_scan_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && rd_pend_r) |-> (CW'(wb_addr_r) < scan_n_r))
    else $error("count write-back outside scanned range");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT && rd_pend_r))
    else $error("result raised outside emit");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (fill_r != '0))
    else $error("emit with empty set");

endmodule
`default_nettype wire
